// ===== rtl/ptb_pkg.sv =====
// ptb_pkg: shared types and constants of the periodic timer bank
// used by ptb_front, ptb_queue, ptb_back and periodic_timer_bank_unit
package ptb_pkg;

  localparam int TimerCount = 8;
  localparam int TimerIdxW = (TimerCount > 1) ? $clog2(TimerCount) : 1;
  localparam logic [TimerIdxW-1:0] TimerLast = TimerIdxW'(TimerCount - 1);

  localparam int QDepth = 2;
  localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [2:0] ActCheck   = 3'd0;
  localparam logic [2:0] ActStart   = 3'd1;
  localparam logic [2:0] ActStop    = 3'd2;
  localparam logic [2:0] ActStopAll = 3'd3;
  localparam logic [2:0] ActPeriod  = 3'd4;
  localparam logic [2:0] ActCount   = 3'd5;
  localparam logic [2:0] ActStage   = 3'd6;

  localparam logic [31:0] PeriodMin    = 32'd500;
  localparam logic [31:0] PeriodReset  = 32'd1000000;
  localparam logic [30:0] StageMax     = 31'h7FFFFFFE;
  localparam logic [31:0] CountMax     = 32'h7FFFFFFF;
  localparam logic [31:0] CountEndless = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    K_CHECK,
    K_START,
    K_STOP,
    K_STOP_ALL,
    K_PERIOD,
    K_COUNT,
    K_STAGE
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [TimerIdxW-1:0]  idx;
    logic [31:0]           arg;
    logic [63:0]           now;
  } q_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } back_state_t;

endpackage

// ===== rtl/ptb_front.sv =====
// ptb_front: accepts requests, decodes the action and clamps the argument
// depends on ptb_pkg; feeds ptb_queue
module ptb_front (
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         action,
  input  logic [2:0]         timer_index,
  input  logic signed [32:0] value,
  input  logic [63:0]        now_us,
  input  logic               q_full,
  output logic               q_push,
  output ptb_pkg::q_entry_t  q_wdata
);
  import ptb_pkg::*;

  logic        idx_ok;
  logic        keep;
  kind_t       kind;
  logic [31:0] arg;

  assign idx_ok = int'(timer_index) < TimerCount;

  always_comb begin
    kind = K_CHECK;
    arg  = 32'd0;
    keep = 1'b0;
    case (action)
      ActCheck: begin
        kind = K_CHECK;
        keep = 1'b1;
      end
      ActStart: begin
        kind = K_START;
        keep = idx_ok;
      end
      ActStop: begin
        kind = K_STOP;
        keep = idx_ok;
      end
      ActStopAll: begin
        kind = K_STOP_ALL;
        keep = 1'b1;
      end
      ActPeriod: begin
        kind = K_PERIOD;
        keep = idx_ok;
        if (value < 33'sd500) begin
          arg = PeriodMin;
        end else begin
          arg = value[31:0];
        end
      end
      ActCount: begin
        kind = K_COUNT;
        keep = idx_ok;
        if (value[32]) begin
          arg = CountEndless;
        end else if (value[31]) begin
          arg = CountMax;
        end else begin
          arg = value[31:0];
        end
      end
      ActStage: begin
        kind = K_STAGE;
        keep = idx_ok;
        if (value[32]) begin
          arg = 32'd0;
        end else if (value[31:0] > {1'b0, StageMax}) begin
          arg = {1'b0, StageMax};
        end else begin
          arg = {1'b0, value[30:0]};
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // ignored requests are taken and dropped here
  assign req_stall     = q_full;
  assign q_push        = req_valid && !q_full && keep;
  assign q_wdata.kind  = kind;
  assign q_wdata.idx   = TimerIdxW'(timer_index);
  assign q_wdata.arg   = arg;
  assign q_wdata.now   = now_us;

endmodule

// ===== rtl/ptb_queue.sv =====
// ptb_queue: short fifo of decoded requests between front and back
// depends on ptb_pkg
module ptb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptb_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output ptb_pkg::q_entry_t rdata
);
  import ptb_pkg::*;

  q_entry_t         mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt == QCntW'(QDepth);
  assign q_valid = cnt != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |=> (cnt <= QCntW'(QDepth)))
    else $error("queue count past depth");

  a_pop_moves_ptr: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> (rd_ptr != $past(rd_ptr) || QDepth == 1))
    else $error("pop did not advance read pointer");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("push without pop did not grow count");

endmodule

// ===== rtl/ptb_back.sv =====
// ptb_back: timer state, command execution, deadline scan and result register
// depends on ptb_pkg; drains ptb_queue
module ptb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ptb_pkg::q_entry_t q_rdata,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [2:0]        fired_index,
  output logic [30:0]       stage_number,
  output logic              run_ended,
  output logic              last
);
  import ptb_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [TimerCount-1:0] running;
  logic [31:0]           period_us     [TimerCount];
  logic [31:0]           repeat_limit  [TimerCount];
  logic [30:0]           stage_counter [TimerCount];
  logic [63:0]           next_fire_us  [TimerCount];

  logic [TimerIdxW-1:0] scan_ix;
  logic [63:0]          scan_now;

  logic                 pend_v;
  logic [TimerIdxW-1:0] pend_ix;
  logic [30:0]          pend_stage;
  logic                 pend_end;

  logic [TimerIdxW-1:0] rd_ix;
  logic                 cur_run;
  logic [31:0]          cur_per;
  logic [31:0]          cur_lim;
  logic [30:0]          cur_stage;
  logic [63:0]          cur_next;
  logic [63:0]          add_a;
  logic [63:0]          sum;
  logic                 fire;
  logic [30:0]          stage_inc;
  logic                 ends;
  logic                 out_free;

  logic start_scan;
  logic exec_cmd;
  logic scan_step;
  logic emit_pend;
  logic emit_last;

  assign rd_ix     = (state == S_SCAN) ? scan_ix : q_rdata.idx;
  assign cur_run   = running[rd_ix];
  assign cur_per   = period_us[rd_ix];
  assign cur_lim   = repeat_limit[rd_ix];
  assign cur_stage = stage_counter[rd_ix];
  assign cur_next  = next_fire_us[rd_ix];

  // one adder: deadline advance on scan, start deadline on command
  assign add_a     = (state == S_SCAN) ? cur_next : q_rdata.now;
  assign sum       = add_a + {32'd0, cur_per};
  assign fire      = cur_run && (scan_now >= cur_next);
  assign stage_inc = (cur_stage >= StageMax) ? StageMax : cur_stage + 1'b1;
  assign ends      = !cur_lim[31] && ({1'b0, stage_inc} > cur_lim);
  assign out_free  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    start_scan = 1'b0;
    exec_cmd   = 1'b0;
    scan_step  = 1'b0;
    emit_pend  = 1'b0;
    emit_last  = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_rdata.kind == K_CHECK) begin
            start_scan = 1'b1;
            state_next = S_SCAN;
          end else begin
            exec_cmd = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // a second firing must push the held one out first
        if (!(fire && pend_v && !out_free)) begin
          scan_step = 1'b1;
          emit_pend = fire && pend_v;
          if (scan_ix == TimerLast) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      scan_now <= q_rdata.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ix <= '0;
    end else if (start_scan) begin
      scan_ix <= '0;
    end else if (scan_step && scan_ix != TimerLast) begin
      scan_ix <= scan_ix + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      for (int i = 0; i < TimerCount; i++) begin
        period_us[i]     <= PeriodReset;
        repeat_limit[i]  <= CountEndless;
        stage_counter[i] <= '0;
        next_fire_us[i]  <= '0;
      end
    end else if (scan_step && fire) begin
      stage_counter[rd_ix] <= stage_inc;
      if (ends) begin
        running[rd_ix] <= 1'b0;
      end else begin
        next_fire_us[rd_ix] <= sum;
      end
    end else if (exec_cmd) begin
      case (q_rdata.kind)
        K_START: begin
          running[rd_ix]      <= 1'b1;
          next_fire_us[rd_ix] <= sum;
        end
        K_STOP:     running[rd_ix] <= 1'b0;
        K_STOP_ALL: running <= '0;
        K_PERIOD:   period_us[rd_ix] <= q_rdata.arg;
        K_COUNT:    repeat_limit[rd_ix] <= q_rdata.arg;
        K_STAGE:    stage_counter[rd_ix] <= q_rdata.arg[30:0];
        default:    running <= running;
      endcase
    end
  end

  // held firing, sent once the next firing or the end of the scan is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (scan_step && fire) begin
      pend_v <= 1'b1;
    end else if (emit_last) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_step && fire) begin
      pend_ix    <= rd_ix;
      pend_stage <= cur_stage + 1'b1;
      pend_end   <= ends;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_pend || emit_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend || emit_last) begin
      fired_index  <= 3'(pend_ix);
      stage_number <= pend_stage;
      run_ended    <= pend_end;
      last         <= emit_last;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (emit_pend || emit_last) |-> out_free)
    else $error("result emitted over an unread result");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE && q_valid))
    else $error("queue popped outside idle");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    emit_last |=> (state == S_IDLE && !pend_v && res_valid && last))
    else $error("final result did not close the scan");

  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    (scan_step && fire && ends) |=> !running[$past(rd_ix)])
    else $error("exhausted timer still running");

endmodule

// ===== rtl/periodic_timer_bank_unit.sv =====
// periodic_timer_bank_unit: top level of the bank of eight periodic timers
// a command is executed by the back end as it leaves the queue; a time check pops,
// then reads and updates one timer a cycle while no output stall holds it, then flushes
// a firing is held until the next firing or the end of the scan
// input stalls while the queue is full
// synchronous reset: all timers stopped, period 1000000, endless count, stage 0
module periodic_timer_bank_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         action,
  input  logic [2:0]         timer_index,
  input  logic signed [32:0] value,
  input  logic [63:0]        now_us,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [2:0]         fired_index,
  output logic [30:0]        stage_number,
  output logic               run_ended,
  output logic               last
);
  import ptb_pkg::*;

  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;

  ptb_front u_front (
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .action      (action),
    .timer_index (timer_index),
    .value       (value),
    .now_us      (now_us),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  ptb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  ptb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .fired_index  (fired_index),
    .stage_number (stage_number),
    .run_ended    (run_ended),
    .last         (last)
  );

endmodule
